// ===== rtl/nps_pkg.sv =====
`timescale 1ns / 1ps
package nps_pkg;

	localparam int SIEVE_DEPTH     = 4096;
	localparam int PRIME_FIELD_MAX = 16383;

	localparam int PIDX_W = 11;
	localparam int PV_W   = 14;
	localparam int IDX_W  = $clog2(SIEVE_DEPTH);
	// odd value 2*i+3 and strike address up to 3*depth
	localparam int VAL_W  = IDX_W + 2;
	localparam int J_W    = IDX_W + 2;
	localparam int CMP_W  = (VAL_W > PV_W) ? VAL_W : PV_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_STRIKE,
		ST_DELIVER
	} nps_state_t;

	typedef enum logic [1:0] {
		PEND_TWO,
		PEND_FOUND,
		PEND_OVF
	} nps_pend_t;

	typedef struct packed {
		logic      wanted_load;
		logic      idx_clr;
		logic      idx_inc;
		logic      pos_init;
		logic      pos_inc;
		logic      clr_wr;
		logic      strike_start;
		logic      strike_wr;
		logic      pend_load;
		nps_pend_t pend_sel;
		logic      out_load;
	} nps_cmd_t;

	typedef struct packed {
		logic in_zero;
		logic idx_last;
		logic flag_set;
		logic pos_hit;
		logic strike_done;
		logic out_busy;
	} nps_sts_t;

endpackage

// ===== rtl/nps_ctrl.sv =====
`timescale 1ns / 1ps
module nps_ctrl
	import nps_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  nps_sts_t sts,
	output nps_cmd_t cmd,
	output logic     in_stall
);

	nps_state_t state_q;
	nps_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.pend_sel = PEND_TWO;
		in_stall = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.wanted_load = 1'b1;
					if (sts.in_zero) begin
						cmd.pend_load = 1'b1;
						cmd.pend_sel  = PEND_TWO;
						state_d       = ST_DELIVER;
					end else begin
						cmd.idx_clr = 1'b1;
						state_d     = ST_CLEAR;
					end
				end
			end
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (sts.idx_last) begin
					cmd.idx_clr  = 1'b1;
					cmd.pos_init = 1'b1;
					state_d      = ST_SCAN_RD;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			ST_SCAN_RD: begin
				state_d = ST_SCAN_CHK;
			end
			ST_SCAN_CHK: begin
				if (sts.flag_set) begin
					if (sts.pos_hit) begin
						cmd.pend_load = 1'b1;
						cmd.pend_sel  = PEND_FOUND;
						state_d       = ST_DELIVER;
					end else begin
						cmd.strike_start = 1'b1;
						state_d          = ST_STRIKE;
					end
				end else if (sts.idx_last) begin
					cmd.pend_load = 1'b1;
					cmd.pend_sel  = PEND_OVF;
					state_d       = ST_DELIVER;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = ST_SCAN_RD;
				end
			end
			ST_STRIKE: begin
				if (!sts.strike_done) begin
					cmd.strike_wr = 1'b1;
				end else if (sts.idx_last) begin
					cmd.pend_load = 1'b1;
					cmd.pend_sel  = PEND_OVF;
					state_d       = ST_DELIVER;
				end else begin
					cmd.idx_inc = 1'b1;
					cmd.pos_inc = 1'b1;
					state_d     = ST_SCAN_RD;
				end
			end
			ST_DELIVER: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/nps_datapath.sv =====
`timescale 1ns / 1ps
module nps_datapath
	import nps_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  nps_cmd_t          cmd,
	output nps_sts_t          sts,
	input  logic [PIDX_W-1:0] prime_index,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [PV_W-1:0]   prime_value,
	output logic              overflow
);

	logic flags_mem [SIEVE_DEPTH];
	logic rd_q;

	logic [PIDX_W-1:0] wanted_q;
	logic [PIDX_W-1:0] pos_q;
	logic [IDX_W-1:0]  idx_q;
	logic [VAL_W-1:0]  step_q;
	logic [J_W-1:0]    j_q;

	logic [PV_W-1:0] pend_value_q;
	logic            pend_ovf_q;
	logic            out_valid_q;
	logic [PV_W-1:0] out_value_q;
	logic            out_ovf_q;

	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic [VAL_W-1:0] cur_value;
	logic [CMP_W-1:0] cur_ext;
	logic             cur_fits;
	logic [J_W-1:0]   j_first;

	// odd value of the flag under the scan pointer
	assign cur_value = {idx_q, 1'b0} + VAL_W'(3);
	assign cur_ext   = CMP_W'(cur_value);
	assign cur_fits  = (cur_ext <= CMP_W'(PRIME_FIELD_MAX));
	// first multiple past the prime itself: i + (2i+3)
	assign j_first   = J_W'({idx_q, 1'b0}) + J_W'(idx_q) + J_W'(3);

	assign wr_en   = cmd.clr_wr | cmd.strike_wr;
	assign wr_addr = cmd.clr_wr ? idx_q : j_q[IDX_W-1:0];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			flags_mem[wr_addr] <= cmd.clr_wr;
		end
		rd_q <= flags_mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.wanted_load) begin
			wanted_q <= prime_index;
		end
		if (cmd.pos_init) begin
			pos_q <= PIDX_W'(1);
		end else if (cmd.pos_inc) begin
			pos_q <= pos_q + PIDX_W'(1);
		end
		if (cmd.idx_clr) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + IDX_W'(1);
		end
		if (cmd.strike_start) begin
			step_q <= cur_value;
			j_q    <= j_first;
		end else if (cmd.strike_wr) begin
			j_q <= j_q + J_W'(step_q);
		end
		if (cmd.pend_load) begin
			case (cmd.pend_sel)
				PEND_TWO: begin
					pend_value_q <= PV_W'(2);
					pend_ovf_q   <= 1'b0;
				end
				PEND_FOUND: begin
					pend_value_q <= cur_fits ? cur_ext[PV_W-1:0] : '0;
					pend_ovf_q   <= ~cur_fits;
				end
				default: begin
					pend_value_q <= '0;
					pend_ovf_q   <= 1'b1;
				end
			endcase
		end
		if (cmd.out_load) begin
			out_value_q <= pend_value_q;
			out_ovf_q   <= pend_ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.in_zero     = (prime_index == '0);
	assign sts.idx_last    = (idx_q == IDX_W'(SIEVE_DEPTH - 1));
	assign sts.flag_set    = rd_q;
	assign sts.pos_hit     = (pos_q == wanted_q);
	assign sts.strike_done = (j_q >= J_W'(SIEVE_DEPTH));
	assign sts.out_busy    = out_valid_q & out_stall;

	assign out_valid   = out_valid_q;
	assign prime_value = out_value_q;
	assign overflow    = out_ovf_q;

`ifndef SYNTHESIS
	a_strike_ahead: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.strike_wr |-> (j_q > J_W'(idx_q)))
		else $error("strike write at or below scan pointer");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(out_valid_q && out_stall))
		else $error("held result overwritten");

	a_pos_below: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.strike_start |-> (pos_q < wanted_q))
		else $error("strike after wanted position reached");

	a_one_writer: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.clr_wr |-> !cmd.strike_wr)
		else $error("clear and strike write together");

	a_out_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid_q)
		else $error("loaded result not shown");
`endif

endmodule

// ===== rtl/nth_prime_sieve_top.sv =====
`timescale 1ns / 1ps
// nth prime by odd-only sieve of eratosthenes
// input channel: prime_index with in_valid / in_stall, a transfer when valid
//   is high and stall is low; index 0 means the prime 2
// output channel: prime_value and overflow with out_valid / out_stall
// one request is worked at a time; in_stall stays high from the transfer of
//   an index until its result is moved into the output register
// index 0: the prime 2 is loaded into the pending register and from there into
//   the output register; the store is not touched
// other indexes: a clearing pass over all SIEVE_DEPTH flags sets every flag, then
//   the scan reads the flags in turn (single read port, registered data)
//   and each prime found strikes its multiples, one write a cycle on the
//   flag memory
// overflow is set and prime_value is 0 when the store holds too few primes
//   (default depth: index 1028 and above)
// a stalled output holds its result; the next index is still taken and its
//   result waits in the block until the output register is free
// asynchronous reset empties the output register and returns to idle;
//   the flag memory is not reset since every request that reads it clears it first
module nth_prime_sieve_top
	import nps_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [PIDX_W-1:0] prime_index,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [PV_W-1:0]   prime_value,
	output logic              overflow
);

	// command and status between controller and datapath
	nps_cmd_t cmd;
	nps_sts_t sts;

	// sequencer: clear sweep, scan, strike loop, delivery
	nps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.sts      (sts),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	// flag memory, scan / strike pointers, position counter, result registers
	nps_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.prime_index (prime_index),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.prime_value (prime_value),
		.overflow    (overflow)
	);

endmodule

// ===== sim/nth_prime_sieve_top_tb.sv =====
`timescale 1ns / 1ps
module nth_prime_sieve_top_tb
	import nps_pkg::*;
;

	localparam int          HALF_PERIOD  = 10;
	localparam int          N_DIRECTED   = 22;
	localparam int          N_RANDOM     = 78;
	// room for the slowest transfer for each of about 100 indexes, several times over
	localparam int unsigned CYCLE_LIMIT  = 12_000_000;
	localparam int          DRAIN_CYCLES = 50;
	localparam int          MAX_REPORTS  = 10;

	// one expected answer: the prime and the beyond-the-store flag
	typedef struct {
		logic [PV_W-1:0] value;
		logic            ovf;
	} prime_answer_t;

	// predicts the n-th prime with a private odd-only sieve and checks the
	// answers in transfer order
	class nth_prime_checker;
		bit            candidate_bits [SIEVE_DEPTH];
		prime_answer_t expected_answers [$];
		int unsigned   requests;
		int unsigned   zero_requests;
		int unsigned   beyond_store;
		int unsigned   checked;
		int unsigned   mismatches;

		function void note_index(logic [PIDX_W-1:0] idx);
			prime_answer_t ans;
			int unsigned   position;
			int unsigned   cand;
			int unsigned   step;
			int unsigned   j;
			requests++;
			ans.value = PV_W'(2);
			ans.ovf   = 1'b0;
			if (idx == '0) begin
				zero_requests++;
			end else begin
				ans.value = '0;
				ans.ovf   = 1'b1;
				foreach (candidate_bits[k])
					candidate_bits[k] = 1'b1;
				position = 1;
				for (cand = 0; cand < SIEVE_DEPTH; cand++) begin
					if (!candidate_bits[cand])
						continue;
					step = 2 * cand + 3;
					if (position == idx) begin
						// a prime too wide for the field reads as beyond the store
						if (step <= PRIME_FIELD_MAX) begin
							ans.value = step[PV_W-1:0];
							ans.ovf   = 1'b0;
						end
						break;
					end
					for (j = cand; j < SIEVE_DEPTH; j += step)
						candidate_bits[j] = 1'b0;
					position++;
				end
				if (ans.ovf)
					beyond_store++;
			end
			expected_answers.push_back(ans);
		endfunction

		function void check_answer(logic [PV_W-1:0] value, logic ovf);
			prime_answer_t want;
			checked++;
			if (expected_answers.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected result: prime_value %0d overflow %0b at %0t",
						value, ovf, $time);
				return;
			end
			want = expected_answers.pop_front();
			if (value !== want.value || ovf !== want.ovf) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("mismatch: expected prime_value %0d overflow %0b, got %0d %0b at %0t",
						want.value, want.ovf, value, ovf, $time);
			end
		endfunction

		function int unsigned pending();
			return expected_answers.size();
		endfunction
	endclass

	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              in_valid    = 1'b0;
	logic              in_stall;
	logic [PIDX_W-1:0] prime_index = '0;
	logic              out_valid;
	logic              out_stall   = 1'b0;
	logic [PV_W-1:0]   prime_value;
	logic              overflow;

	nth_prime_checker  book;
	bit                quiet_mode  = 1'b0;
	int unsigned       stall_left  = 0;
	int unsigned       out_hold;
	int unsigned       cycle_count = 0;

	// directed indexes: zero and its repeats, first few primes, alternating bit
	// patterns, the last prime in the store, the first one beyond it, all ones
	logic [PIDX_W-1:0] directed_idx [N_DIRECTED] = '{
		11'd0,    11'd1,    11'd2,    11'd3,    11'd4,    11'd5,
		11'd10,   11'd0,    11'd0,    11'd31,   11'd100,  11'd255,
		11'd256,  11'd512,  11'd682,  11'd1000, 11'd1024, 11'd1026,
		11'd1027, 11'd1028, 11'd1365, 11'd2047
	};

	nth_prime_sieve_top u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.prime_index (prime_index),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.prime_value (prime_value),
		.overflow    (overflow)
	);

	always begin
		#(HALF_PERIOD) clk = 1'b1;
		#(HALF_PERIOD) clk = 1'b0;
	end

	// hard stop if the block hangs
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, book.pending());
			$display("nth_prime_sieve_top test failed");
			$finish;
		end
	end

	// input monitor: every index transfer gets its expected answer queued
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			book.note_index(prime_index);
	end

	// output side: check each transfer, then hold stall for a random number of
	// cycles in which a result is on offer, so every result may be held back
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				book.check_answer(prime_value, overflow);
				out_hold = quiet_mode ? 0 : $urandom_range(0, 4);
				stall_left <= out_hold;
				out_stall  <= (out_hold != 0);
			end else if (out_valid && stall_left != 0) begin
				stall_left <= stall_left - 1;
				out_stall  <= (stall_left > 1);
			end
		end
	end

	// offer one index after a random gap and hold it until the transfer;
	// valid is only lowered when a gap follows, so back-to-back stays high
	task automatic send_index(input logic [PIDX_W-1:0] idx);
		int unsigned gap;
		gap = quiet_mode ? 0 : $urandom_range(0, 4);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		prime_index <= idx;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	initial begin
		int unsigned k;
		int unsigned pick;
		logic [PIDX_W-1:0] idx;
		book = new();

		// reset once, released on a rising edge
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed part with random gaps on both sides
		for (k = 0; k < N_DIRECTED; k++)
			send_index(directed_idx[k]);

		// random part: mostly small indexes since the sieve cost grows with the
		// index; a few near the store boundary and beyond it; the second block
		// of twenty runs with no gaps or stalls at all
		for (k = 0; k < N_RANDOM; k++) begin
			quiet_mode = ((k / 20) % 4 == 1);
			pick = $urandom_range(0, 99);
			if (pick < 12)
				idx = '0;
			else if (pick < 62)
				idx = PIDX_W'($urandom_range(1, 63));
			else if (pick < 80)
				idx = PIDX_W'($urandom_range(64, 1027));
			else if (pick < 88)
				idx = PIDX_W'($urandom_range(1020, 1035));
			else
				idx = PIDX_W'($urandom_range(1028, 2047));
			send_index(idx);
		end
		in_valid   <= 1'b0;
		quiet_mode = 1'b0;

		// drain, then leave room for any stray result
		while (book.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d index transfers (%0d for index zero, %0d beyond the store)",
			book.requests, book.zero_requests, book.beyond_store);
		$display("%0d results checked, %0d mismatches, %0d cycles",
			book.checked, book.mismatches, cycle_count);
		if (book.mismatches == 0)
			$display("nth_prime_sieve_top test passed");
		else
			$display("nth_prime_sieve_top test failed");
		$finish;
	end

endmodule
